[rtl/fncr_pkg.sv]
// Shared constants, types and helper functions for the free-network constraint row builder.
package fncr_pkg;

   localparam int COORD_BITS    = 40;
   localparam int DIFF_BITS     = COORD_BITS + 1;
   localparam int COL_BITS      = 16;
   localparam int ROW_BITS      = 6;
   localparam int VAL_BITS      = 64;
   localparam int FRAC_BITS     = 24;
   localparam int NUM_KINDS     = 7;
   localparam int NUM_STEPS     = 12;
   localparam int STEP_BITS     = 4;
   localparam int NUM_SUMS      = 4;
   localparam int SUM_SEL_BITS  = 2;
   localparam int KIND_BITS     = 3;
   localparam int CNT_BITS      = 17;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = NUM_KINDS * ROW_BITS;
   localparam int QDEPTH        = 2;
   localparam int QPTR_BITS     = 1;
   localparam int QCNT_BITS     = 2;
   localparam int LO_BITS       = 21;
   localparam int HI_BITS       = DIFF_BITS - LO_BITS;
   localparam int PPLO_BITS     = DIFF_BITS + LO_BITS + 1;
   localparam int PPHI_BITS     = DIFF_BITS + HI_BITS;
   localparam int PROD_BITS     = 2 * DIFF_BITS;
   localparam int ACC_BITS      = VAL_BITS + FRAC_BITS;

   localparam logic [CNT_BITS-1:0]        MAX_POINTS = CNT_BITS'(65536);
   localparam logic signed [VAL_BITS-1:0] Q_ONE      = VAL_BITS'(64'sd16777216);
   localparam logic signed [VAL_BITS-1:0] VAL_MAX    = {1'b0, {(VAL_BITS-1){1'b1}}};
   localparam logic signed [VAL_BITS-1:0] VAL_MIN    = {1'b1, {(VAL_BITS-1){1'b0}}};
   localparam logic [ACC_BITS-1:0]        ROUND_HALF = ACC_BITS'(1) << (FRAC_BITS - 1);

   localparam logic [KIND_BITS-1:0] KIND_DX    = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_DY    = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_DZ    = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_RX    = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_RY    = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_RZ    = 3'd5;
   localparam logic [KIND_BITS-1:0] KIND_SCALE = 3'd6;

   localparam logic [SUM_SEL_BITS-1:0] SUM_RX    = 2'd0;
   localparam logic [SUM_SEL_BITS-1:0] SUM_RY    = 2'd1;
   localparam logic [SUM_SEL_BITS-1:0] SUM_RZ    = 2'd2;
   localparam logic [SUM_SEL_BITS-1:0] SUM_SCALE = 2'd3;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_EST_X     = 3'd0,
      CSR_EST_Y     = 3'd1,
      CSR_EST_Z     = 3'd2,
      CSR_REF_X     = 3'd3,
      CSR_REF_Y     = 3'd4,
      CSR_REF_Z     = 3'd5,
      CSR_ENABLE    = 3'd6,
      CSR_ROW_TABLE = 3'd7
   } csr_index_type;

   typedef enum logic {
      CMD_POINT  = 1'b0,
      CMD_FINISH = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                       cmd;
      logic [2:0]                    vm;
      logic [2:0][COL_BITS-1:0]      col;
      logic [2:0][COORD_BITS-1:0]    p;
      logic [2:0][COORD_BITS-1:0]    e;
      logic [2:0][DIFF_BITS-1:0]     dp;
      logic [2:0][DIFF_BITS-1:0]     de;
   } fncr_item_type;

   typedef struct packed {
      logic [QCNT_BITS-1:0] count;
      logic                 empty;
      logic                 full;
   } fncr_qstat_type;

   typedef struct packed {
      logic                    neg;
      logic                    first;
      logic                    last;
      logic                    kind_en;
      logic [SUM_SEL_BITS-1:0] sel;
   } fncr_acc_tag_type;

   typedef struct packed {
      logic                 valid;
      logic [DIFF_BITS-1:0] a;
      logic [DIFF_BITS-1:0] b;
      fncr_acc_tag_type     tag;
      logic                 inc;
      logic                 clear;
   } fncr_acc_op_type;

   function automatic logic signed [VAL_BITS-1:0] sat_add(
      input logic signed [VAL_BITS-1:0] a,
      input logic signed [VAL_BITS-1:0] b
   );
      logic signed [VAL_BITS-1:0] s;
      s = a + b;
      if ((a[VAL_BITS-1] == b[VAL_BITS-1]) && (s[VAL_BITS-1] != a[VAL_BITS-1])) begin
         s = a[VAL_BITS-1] ? VAL_MIN : VAL_MAX;
      end
      return s;
   endfunction

   function automatic logic signed [VAL_BITS-1:0] sat_neg(
      input logic signed [VAL_BITS-1:0] a
   );
      return (a == VAL_MIN) ? VAL_MAX : -a;
   endfunction

endpackage

[rtl/free_network_constraint_rows.sv]
// Top level: configuration registers, input side, queue, sequencer and product pipeline.
//
//   port group   direction   handshake            carries
//   req_*        in          req_valid/req_ready  one point or finish item
//   rsp_*        out         rsp_valid/rsp_ready  one coefficient or misclosure term
//   csr_*        in          csr_wr_en            register write, no read-back
//
// A point item takes one sequencer step per possible coefficient,
// each step also feeding one 41x41 product into the shared two-multiplier pipeline.
// A finish item waits for that pipeline to drain, then takes 7 steps.
// Reset clears registers, sums, count, queue and output; no clearing pass.
// A stalled result output holds the sequencer only on steps that emit; two items queue.
module free_network_constraint_rows import fncr_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_cmd,
   input  logic [COORD_BITS-1:0]     req_prov_x,
   input  logic [COORD_BITS-1:0]     req_prov_y,
   input  logic [COORD_BITS-1:0]     req_prov_z,
   input  logic [COORD_BITS-1:0]     req_est_x,
   input  logic [COORD_BITS-1:0]     req_est_y,
   input  logic [COORD_BITS-1:0]     req_est_z,
   input  logic [2:0]                req_variable_mask,
   input  logic [COL_BITS-1:0]       req_col_x,
   input  logic [COL_BITS-1:0]       req_col_y,
   input  logic [COL_BITS-1:0]       req_col_z,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [ROW_BITS-1:0]       rsp_row,
   output logic [COL_BITS-1:0]       rsp_col,
   output logic [VAL_BITS-1:0]       rsp_value,
   output logic                      rsp_is_misclosure,
   output logic                      rsp_last,
   input  logic                      csr_wr_en,
   input  logic [CSR_IDX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [2:0][COORD_BITS-1:0]        est_ff;
   logic [2:0][COORD_BITS-1:0]        ref_ff;
   logic [NUM_KINDS-1:0]              enable_ff;
   logic [CSR_DATA_BITS-1:0]          row_table_ff;

   fncr_qstat_type                    q_stat;
   fncr_item_type                     push_item;
   fncr_item_type                     q_head;
   logic                              push, q_pop;
   fncr_acc_op_type                   acc_op;
   logic                              acc_busy;
   logic [NUM_SUMS-1:0][VAL_BITS-1:0] acc_sums;
   logic [CNT_BITS-1:0]               acc_count;

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff       <= '0;
         ref_ff       <= '0;
         enable_ff    <= '0;
         row_table_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_EST_X:     est_ff[0]    <= csr_wdata[COORD_BITS-1:0];
            CSR_EST_Y:     est_ff[1]    <= csr_wdata[COORD_BITS-1:0];
            CSR_EST_Z:     est_ff[2]    <= csr_wdata[COORD_BITS-1:0];
            CSR_REF_X:     ref_ff[0]    <= csr_wdata[COORD_BITS-1:0];
            CSR_REF_Y:     ref_ff[1]    <= csr_wdata[COORD_BITS-1:0];
            CSR_REF_Z:     ref_ff[2]    <= csr_wdata[COORD_BITS-1:0];
            CSR_ENABLE:    enable_ff    <= csr_wdata[NUM_KINDS-1:0];
            CSR_ROW_TABLE: row_table_ff <= csr_wdata;
         endcase
      end
   end

   fncr_front u_front (
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_cmd           (req_cmd),
      .req_prov_x        (req_prov_x),
      .req_prov_y        (req_prov_y),
      .req_prov_z        (req_prov_z),
      .req_est_x         (req_est_x),
      .req_est_y         (req_est_y),
      .req_est_z         (req_est_z),
      .req_variable_mask (req_variable_mask),
      .req_col_x         (req_col_x),
      .req_col_y         (req_col_y),
      .req_col_z         (req_col_z),
      .cfg_est           (est_ff),
      .q_stat            (q_stat),
      .push              (push),
      .push_item         (push_item)
   );

   fncr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (q_pop),
      .head      (q_head),
      .q_stat    (q_stat)
   );

   fncr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_stat            (q_stat),
      .q_head            (q_head),
      .q_pop             (q_pop),
      .cfg_enable        (enable_ff),
      .cfg_row_table     (row_table_ff),
      .cfg_est           (est_ff),
      .cfg_ref           (ref_ff),
      .acc_busy          (acc_busy),
      .acc_sums          (acc_sums),
      .acc_count         (acc_count),
      .acc_op            (acc_op),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_row           (rsp_row),
      .rsp_col           (rsp_col),
      .rsp_value         (rsp_value),
      .rsp_is_misclosure (rsp_is_misclosure),
      .rsp_last          (rsp_last)
   );

   fncr_accum u_accum (
      .clock (clock),
      .reset (reset),
      .op    (acc_op),
      .busy  (acc_busy),
      .sums  (acc_sums),
      .count (acc_count)
   );

   assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCNT_BITS'(QDEPTH))
      else $error("item queue over depth");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_is_misclosure |-> rsp_col == '0)
      else $error("misclosure term with nonzero column");

   assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_stat.empty)
      else $error("pop from empty item queue");

   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

endmodule

[rtl/fncr_front.sv]
// Input side: takes a transfer, forms center-relative coordinates and pushes the item.
module fncr_front import fncr_pkg::*; (
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic                        req_cmd,
   input  logic [COORD_BITS-1:0]       req_prov_x,
   input  logic [COORD_BITS-1:0]       req_prov_y,
   input  logic [COORD_BITS-1:0]       req_prov_z,
   input  logic [COORD_BITS-1:0]       req_est_x,
   input  logic [COORD_BITS-1:0]       req_est_y,
   input  logic [COORD_BITS-1:0]       req_est_z,
   input  logic [2:0]                  req_variable_mask,
   input  logic [COL_BITS-1:0]         req_col_x,
   input  logic [COL_BITS-1:0]         req_col_y,
   input  logic [COL_BITS-1:0]         req_col_z,
   input  logic [2:0][COORD_BITS-1:0]  cfg_est,
   input  fncr_qstat_type              q_stat,
   output logic                        push,
   output fncr_item_type               push_item
);

   logic [2:0][COORD_BITS-1:0] p;
   logic [2:0][COORD_BITS-1:0] e;

   assign req_ready = !q_stat.full;
   assign push      = req_valid && req_ready;

   assign p = {req_prov_z, req_prov_y, req_prov_x};
   assign e = {req_est_z, req_est_y, req_est_x};

   always_comb begin
      push_item.cmd = cmd_type'(req_cmd);
      push_item.vm  = req_variable_mask;
      push_item.col = {req_col_z, req_col_y, req_col_x};
      push_item.p   = p;
      push_item.e   = e;
      for (int i = 0; i < 3; i++) begin
         push_item.dp[i] = DIFF_BITS'($signed({p[i][COORD_BITS-1], p[i]})
                                    - $signed({cfg_est[i][COORD_BITS-1], cfg_est[i]}));
         push_item.de[i] = DIFF_BITS'($signed({e[i][COORD_BITS-1], e[i]})
                                    - $signed({cfg_est[i][COORD_BITS-1], cfg_est[i]}));
      end
   end

endmodule

[rtl/fncr_queue.sv]
// Two-entry item queue between the input side and the sequencer.
module fncr_queue import fncr_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  fncr_item_type  push_item,
   input  logic           pop,
   output fncr_item_type  head,
   output fncr_qstat_type q_stat
);

   fncr_item_type        ent_ff [QDEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff;
   logic [QPTR_BITS-1:0] rd_ptr_ff;
   logic [QCNT_BITS-1:0] count_ff;
   logic [QCNT_BITS-1:0] count_in;

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QCNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_BITS'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head         = ent_ff[rd_ptr_ff];
   assign q_stat.count = count_ff;
   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == QCNT_BITS'(QDEPTH));

endmodule

[rtl/fncr_accum.sv]
// Shared product pipeline, running rotation and scale sums, and point counter.
module fncr_accum import fncr_pkg::*; (
   input  logic                               clock,
   input  logic                               reset,
   input  fncr_acc_op_type                    op,
   output logic                               busy,
   output logic [NUM_SUMS-1:0][VAL_BITS-1:0]  sums,
   output logic [CNT_BITS-1:0]                count
);

   logic                           v0_ff, v1_ff, v2_ff, v3_ff, v4_ff;
   logic signed [DIFF_BITS-1:0]    a0_ff, b0_ff;
   fncr_acc_tag_type               tag0_ff, tag1_ff, tag2_ff, tag4_ff;
   logic signed [PPLO_BITS-1:0]    pplo_ff;
   logic signed [PPHI_BITS-1:0]    pphi_ff;
   logic signed [PROD_BITS-1:0]    prod_ff;
   logic signed [PROD_BITS-1:0]    prod_in;
   logic signed [ACC_BITS-1:0]     acc_ff;
   logic signed [ACC_BITS-1:0]     acc_in;
   logic signed [ACC_BITS-1:0]     prod_ext;
   fncr_acc_tag_type               tag3_ff;
   logic [ACC_BITS-1:0]            rnd_sum;
   logic signed [VAL_BITS-1:0]     rnd_ff;
   logic signed [VAL_BITS-1:0]     sum_ff [NUM_SUMS];
   logic [CNT_BITS-1:0]            count_ff;
   logic [CNT_BITS-1:0]            count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v0_ff <= op.valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff && tag2_ff.last;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      a0_ff   <= op.a;
      b0_ff   <= op.b;
      tag0_ff <= op.tag;
      pplo_ff <= a0_ff * $signed({1'b0, b0_ff[LO_BITS-1:0]});
      pphi_ff <= a0_ff * $signed(b0_ff[DIFF_BITS-1:LO_BITS]);
      tag1_ff <= tag0_ff;
      prod_ff <= prod_in;
      tag2_ff <= tag1_ff;
      tag3_ff <= tag2_ff;
      rnd_ff  <= rnd_sum[ACC_BITS-1:FRAC_BITS];
      tag4_ff <= tag3_ff;
   end

   assign prod_in = (PROD_BITS'(pphi_ff) <<< LO_BITS) + PROD_BITS'(pplo_ff);
   assign prod_ext = ACC_BITS'(prod_ff);

   always_comb begin
      acc_in = acc_ff;
      if (v2_ff) begin
         if (tag2_ff.first) begin
            acc_in = tag2_ff.neg ? -prod_ext : prod_ext;
         end else begin
            acc_in = tag2_ff.neg ? acc_ff - prod_ext : acc_ff + prod_ext;
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign rnd_sum = acc_ff + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (reset || op.clear) begin
         for (int i = 0; i < NUM_SUMS; i++) begin
            sum_ff[i] <= '0;
         end
      end else if (v4_ff && tag4_ff.kind_en) begin
         sum_ff[tag4_ff.sel] <= sat_add(sum_ff[tag4_ff.sel], rnd_ff);
      end
   end

   always_comb begin
      count_in = count_ff;
      if (op.clear) begin
         count_in = '0;
      end else if (op.inc && (count_ff < MAX_POINTS)) begin
         count_in = count_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_SUMS; i++) begin
         sums[i] = sum_ff[i];
      end
   end

   assign count = count_ff;
   assign busy  = v0_ff || v1_ff || v2_ff || v3_ff || v4_ff;

endmodule

[rtl/fncr_back.sv]
// Sequencer: steps through each item, feeds the product pipeline and registers results.
module fncr_back import fncr_pkg::*; (
   input  logic                               clock,
   input  logic                               reset,
   input  fncr_qstat_type                     q_stat,
   input  fncr_item_type                      q_head,
   output logic                               q_pop,
   input  logic [NUM_KINDS-1:0]               cfg_enable,
   input  logic [CSR_DATA_BITS-1:0]           cfg_row_table,
   input  logic [2:0][COORD_BITS-1:0]         cfg_est,
   input  logic [2:0][COORD_BITS-1:0]         cfg_ref,
   input  logic                               acc_busy,
   input  logic [NUM_SUMS-1:0][VAL_BITS-1:0]  acc_sums,
   input  logic [CNT_BITS-1:0]                acc_count,
   output fncr_acc_op_type                    acc_op,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [ROW_BITS-1:0]                rsp_row,
   output logic [COL_BITS-1:0]                rsp_col,
   output logic [VAL_BITS-1:0]                rsp_value,
   output logic                               rsp_is_misclosure,
   output logic                               rsp_last
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_POINT  = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_FINISH = 4'b1000
   } fncr_state_type;

   fncr_state_type              state_ff, state_in;
   logic [STEP_BITS-1:0]        step_ff, step_in;
   fncr_item_type               cur_ff, cur_in;
   logic [NUM_STEPS-1:0]        emask_ff, emask_in;
   logic signed [DIFF_BITS-1:0] diff_ff [3];

   logic                        rsp_valid_ff;
   logic [ROW_BITS-1:0]         row_ff;
   logic [COL_BITS-1:0]         col_ff;
   logic [VAL_BITS-1:0]         value_ff;
   logic                        misc_ff;
   logic                        last_ff;

   logic                        active, emit, out_free, fire, last_step, load, is_last;
   logic [NUM_STEPS:0]          upto;
   logic [NUM_STEPS-1:0]        point_mask;
   logic [KIND_BITS-1:0]        kind;
   logic [1:0]                  axis;
   logic signed [VAL_BITS-1:0]  coef;
   logic signed [VAL_BITS-1:0]  fin_value;
   logic [STEP_BITS-1:0]        sum_step;
   logic [ROW_BITS-1:0]         row_sel;
   logic [COL_BITS-1:0]         col_sel;
   logic signed [VAL_BITS-1:0]  value_sel;
   logic signed [DIFF_BITS-1:0] dp0, dp1, dp2;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         diff_ff[i] <= DIFF_BITS'($signed({cfg_ref[i][COORD_BITS-1], cfg_ref[i]})
                                - $signed({cfg_est[i][COORD_BITS-1], cfg_est[i]}));
      end
   end

   assign point_mask = {
      cfg_enable[KIND_SCALE] & q_head.vm[2], cfg_enable[KIND_SCALE] & q_head.vm[1],
      cfg_enable[KIND_SCALE] & q_head.vm[0], cfg_enable[KIND_RZ] & q_head.vm[1],
      cfg_enable[KIND_RZ] & q_head.vm[0],    cfg_enable[KIND_RY] & q_head.vm[2],
      cfg_enable[KIND_RY] & q_head.vm[0],    cfg_enable[KIND_RX] & q_head.vm[2],
      cfg_enable[KIND_RX] & q_head.vm[1],    cfg_enable[KIND_DZ] & q_head.vm[2],
      cfg_enable[KIND_DY] & q_head.vm[1],    cfg_enable[KIND_DX] & q_head.vm[0]
   };

   assign dp0 = $signed(cur_ff.dp[0]);
   assign dp1 = $signed(cur_ff.dp[1]);
   assign dp2 = $signed(cur_ff.dp[2]);

   always_comb begin
      kind = KIND_DX;
      axis = 2'd0;
      coef = Q_ONE;
      unique case (step_ff)
         4'd0: begin kind = KIND_DX; axis = 2'd0; coef = Q_ONE; end
         4'd1: begin kind = KIND_DY; axis = 2'd1; coef = Q_ONE; end
         4'd2: begin kind = KIND_DZ; axis = 2'd2; coef = Q_ONE; end
         4'd3: begin kind = KIND_RX; axis = 2'd1; coef = -VAL_BITS'(dp2); end
         4'd4: begin kind = KIND_RX; axis = 2'd2; coef = VAL_BITS'(dp1); end
         4'd5: begin kind = KIND_RY; axis = 2'd0; coef = VAL_BITS'(dp2); end
         4'd6: begin kind = KIND_RY; axis = 2'd2; coef = -VAL_BITS'(dp0); end
         4'd7: begin kind = KIND_RZ; axis = 2'd0; coef = -VAL_BITS'(dp1); end
         4'd8: begin kind = KIND_RZ; axis = 2'd1; coef = VAL_BITS'(dp0); end
         4'd9: begin
            kind = KIND_SCALE; axis = 2'd0; coef = VAL_BITS'($signed(cur_ff.p[0]));
         end
         4'd10: begin
            kind = KIND_SCALE; axis = 2'd1; coef = VAL_BITS'($signed(cur_ff.p[1]));
         end
         4'd11: begin
            kind = KIND_SCALE; axis = 2'd2; coef = VAL_BITS'($signed(cur_ff.p[2]));
         end
         default: begin kind = KIND_DX; axis = 2'd0; coef = Q_ONE; end
      endcase
   end

   assign sum_step = step_ff - STEP_BITS'(KIND_RX);

   always_comb begin
      if (step_ff < STEP_BITS'(KIND_RX)) begin
         fin_value = VAL_BITS'($signed({1'b0, acc_count}) * diff_ff[step_ff[1:0]]);
      end else begin
         fin_value = sat_neg($signed(acc_sums[sum_step[SUM_SEL_BITS-1:0]]));
      end
   end

   always_comb begin
      if (state_ff == ST_FINISH) begin
         row_sel   = cfg_row_table[ROW_BITS*step_ff[KIND_BITS-1:0] +: ROW_BITS];
         col_sel   = '0;
         value_sel = fin_value;
      end else begin
         row_sel   = cfg_row_table[ROW_BITS*kind +: ROW_BITS];
         col_sel   = cur_ff.col[axis];
         value_sel = coef;
      end
   end

   assign active    = (state_ff == ST_POINT) || (state_ff == ST_FINISH);
   assign emit      = active && emask_ff[step_ff];
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign fire      = active && (!emit || out_free);
   assign last_step = (state_ff == ST_POINT) ? (step_ff == STEP_BITS'(NUM_STEPS - 1))
                                              : (step_ff == STEP_BITS'(NUM_KINDS - 1));
   assign load      = !q_stat.empty && ((state_ff == ST_IDLE) || (fire && last_step));
   assign q_pop     = load;
   assign upto      = ((NUM_STEPS+1)'(1) << (step_ff + STEP_BITS'(1))) - (NUM_STEPS+1)'(1);
   assign is_last   = (emask_ff & ~upto[NUM_STEPS-1:0]) == '0;

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cur_in   = cur_ff;
      emask_in = emask_ff;
      if (load) begin
         cur_in  = q_head;
         step_in = '0;
         if (q_head.cmd == CMD_FINISH) begin
            state_in = ST_DRAIN;
            emask_in = {{(NUM_STEPS-NUM_KINDS){1'b0}}, cfg_enable};
         end else begin
            state_in = ST_POINT;
            emask_in = point_mask;
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               state_in = ST_IDLE;
            end
            ST_POINT, ST_FINISH: begin
               if (fire && last_step) begin
                  state_in = ST_IDLE;
               end else if (fire) begin
                  step_in = step_ff + STEP_BITS'(1);
               end
            end
            ST_DRAIN: begin
               if (!acc_busy) begin
                  state_in = ST_FINISH;
               end
            end
            default: begin
               state_in = ST_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= '0;
         emask_ff <= '0;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         emask_ff <= emask_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_comb begin
      acc_op             = '0;
      acc_op.valid       = (state_ff == ST_POINT) && fire;
      acc_op.inc         = (state_ff == ST_POINT) && fire && (step_ff == '0);
      acc_op.clear       = (state_ff == ST_FINISH) && fire && last_step;
      acc_op.tag.neg     = step_ff[0] && (step_ff < STEP_BITS'(6));
      acc_op.tag.first   = (step_ff == 4'd0) || (step_ff == 4'd2) || (step_ff == 4'd4)
                         || (step_ff == 4'd6);
      acc_op.tag.last    = (step_ff == 4'd1) || (step_ff == 4'd3) || (step_ff == 4'd5)
                         || (step_ff == 4'd11);
      if (step_ff < 4'd2) begin
         acc_op.tag.sel = SUM_RX;
      end else if (step_ff < 4'd4) begin
         acc_op.tag.sel = SUM_RY;
      end else if (step_ff < 4'd6) begin
         acc_op.tag.sel = SUM_RZ;
      end else begin
         acc_op.tag.sel = SUM_SCALE;
      end
      acc_op.tag.kind_en = cfg_enable[KIND_RX + KIND_BITS'(acc_op.tag.sel)];
      unique case (step_ff)
         4'd0:  begin acc_op.a = cur_ff.dp[1]; acc_op.b = cur_ff.de[2]; end
         4'd1:  begin acc_op.a = cur_ff.dp[2]; acc_op.b = cur_ff.de[1]; end
         4'd2:  begin acc_op.a = cur_ff.dp[2]; acc_op.b = cur_ff.de[0]; end
         4'd3:  begin acc_op.a = cur_ff.dp[0]; acc_op.b = cur_ff.de[2]; end
         4'd4:  begin acc_op.a = cur_ff.dp[0]; acc_op.b = cur_ff.de[1]; end
         4'd5:  begin acc_op.a = cur_ff.dp[1]; acc_op.b = cur_ff.de[0]; end
         4'd6:  begin
            acc_op.a = DIFF_BITS'($signed(cur_ff.p[0]));
            acc_op.b = DIFF_BITS'($signed(cur_ff.e[0]));
         end
         4'd7:  begin
            acc_op.a = DIFF_BITS'($signed(cfg_est[0]));
            acc_op.b = DIFF_BITS'($signed(cfg_est[0]));
         end
         4'd8:  begin
            acc_op.a = DIFF_BITS'($signed(cur_ff.p[1]));
            acc_op.b = DIFF_BITS'($signed(cur_ff.e[1]));
         end
         4'd9:  begin
            acc_op.a = DIFF_BITS'($signed(cfg_est[1]));
            acc_op.b = DIFF_BITS'($signed(cfg_est[1]));
         end
         4'd10: begin
            acc_op.a = DIFF_BITS'($signed(cur_ff.p[2]));
            acc_op.b = DIFF_BITS'($signed(cur_ff.e[2]));
         end
         4'd11: begin
            acc_op.a = DIFF_BITS'($signed(cfg_est[2]));
            acc_op.b = DIFF_BITS'($signed(cfg_est[2]));
         end
         default: begin acc_op.a = '0; acc_op.b = '0; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit && fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit && fire) begin
         row_ff   <= row_sel;
         col_ff   <= col_sel;
         value_ff <= value_sel;
         misc_ff  <= (state_ff == ST_FINISH);
         last_ff  <= is_last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_row           = row_ff;
   assign rsp_col           = col_ff;
   assign rsp_value         = value_ff;
   assign rsp_is_misclosure = misc_ff;
   assign rsp_last          = last_ff;

endmodule

[bench/tb_top.sv]
// Self-checking testbench for the free-network constraint row builder.
module tb_top;
   import fncr_pkg::*;

   typedef struct packed {
      cmd_type                    cmd;
      logic [2:0][COORD_BITS-1:0] prov;
      logic [2:0][COORD_BITS-1:0] est;
      logic [2:0]                 vm;
      logic [2:0][COL_BITS-1:0]   col;
   } point_item_type;

   typedef struct packed {
      logic [ROW_BITS-1:0]        row;
      logic [COL_BITS-1:0]        col;
      logic signed [VAL_BITS-1:0] value;
      logic                       is_misclosure;
      logic                       last;
   } row_term_type;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 60;
   localparam logic signed [127:0] WIDE_MAX = VAL_MAX;
   localparam logic signed [127:0] WIDE_MIN = VAL_MIN;
   localparam logic signed [127:0] HALF_LSB = 128'sd8388608;
   localparam logic [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam logic [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
   localparam logic [NUM_KINDS-1:0] ALL_KINDS = '1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [ROW_BITS-1:0] rsp_row;
   logic [COL_BITS-1:0] rsp_col;
   logic [VAL_BITS-1:0] rsp_value;
   logic rsp_is_misclosure;
   logic rsp_last;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   point_item_type drive_item = '0;
   point_item_type pending_items[$];
   row_term_type expected_terms[$];

   logic [COORD_BITS-1:0] cfg_est[3];
   logic [COORD_BITS-1:0] cfg_ref[3];
   logic [NUM_KINDS-1:0] cfg_en = '0;
   logic [CSR_DATA_BITS-1:0] cfg_rows = '0;
   logic signed [VAL_BITS-1:0] rot_x_sum = '0, rot_y_sum = '0, rot_z_sum = '0, scale_sum = '0;
   logic [CNT_BITS-1:0] point_count = '0;

   int accept_count = 0;
   int drive_taken = 0;
   int burst_left = 0;
   int gap_left = 0;
   int mismatch_count = 0;
   int cycle_count = 0;
   int ready_phase = 0;
   logic sender_steady = 1'b0;
   logic [15:0] ready_pattern = '1;

   free_network_constraint_rows dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_cmd(drive_item.cmd),
      .req_prov_x(drive_item.prov[0]), .req_prov_y(drive_item.prov[1]),
      .req_prov_z(drive_item.prov[2]),
      .req_est_x(drive_item.est[0]), .req_est_y(drive_item.est[1]),
      .req_est_z(drive_item.est[2]),
      .req_variable_mask(drive_item.vm),
      .req_col_x(drive_item.col[0]), .req_col_y(drive_item.col[1]),
      .req_col_z(drive_item.col[2]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_row(rsp_row), .rsp_col(rsp_col),
      .rsp_value(rsp_value), .rsp_is_misclosure(rsp_is_misclosure), .rsp_last(rsp_last),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic signed [VAL_BITS-1:0] clamp64(input logic signed [127:0] v);
      if (v > WIDE_MAX) return VAL_MAX;
      if (v < WIDE_MIN) return VAL_MIN;
      return v[VAL_BITS-1:0];
   endfunction

   function automatic logic signed [VAL_BITS-1:0] accumulate(
      input logic signed [VAL_BITS-1:0] s,
      input logic signed [127:0] q48
   );
      logic signed [127:0] a, b;
      a = s;
      b = clamp64((q48 + HALF_LSB) >>> FRAC_BITS);
      return clamp64(a + b);
   endfunction

   task automatic build_expected_rows(input point_item_type it);
      logic signed [127:0] c[3], p[3], e[3], dp[3], de[3], acc, w, cnt;
      row_term_type terms[$];
      row_term_type t;
      int i;
      for (i = 0; i < 3; i++) begin
         c[i] = $signed(cfg_est[i]);
         p[i] = $signed(it.prov[i]);
         e[i] = $signed(it.est[i]);
         dp[i] = p[i] - c[i];
         de[i] = e[i] - c[i];
      end
      t = '0;
      if (it.cmd == CMD_FINISH) begin
         cnt = point_count;
         t.is_misclosure = 1'b1;
         for (i = 0; i < 3; i++) begin
            if (cfg_en[i]) begin
               w = $signed(cfg_ref[i]);
               t.row = cfg_rows[ROW_BITS*i +: ROW_BITS];
               t.value = clamp64(cnt * (w - c[i]));
               terms.push_back(t);
            end
         end
         for (i = KIND_RX; i <= KIND_SCALE; i++) begin
            if (cfg_en[i]) begin
               case (i)
                  KIND_RX: w = rot_x_sum;
                  KIND_RY: w = rot_y_sum;
                  KIND_RZ: w = rot_z_sum;
                  default: w = scale_sum;
               endcase
               t.row = cfg_rows[ROW_BITS*i +: ROW_BITS];
               t.value = clamp64(-w);
               terms.push_back(t);
            end
         end
         rot_x_sum = '0;
         rot_y_sum = '0;
         rot_z_sum = '0;
         scale_sum = '0;
         point_count = '0;
      end else begin
         for (i = 0; i < 3; i++) begin
            if (cfg_en[i] && it.vm[i]) begin
               t.row = cfg_rows[ROW_BITS*i +: ROW_BITS];
               t.col = it.col[i];
               t.value = Q_ONE;
               terms.push_back(t);
            end
         end
         if (cfg_en[KIND_RX]) begin
            t.row = cfg_rows[ROW_BITS*KIND_RX +: ROW_BITS];
            if (it.vm[1]) begin
               t.col = it.col[1];
               t.value = clamp64(-dp[2]);
               terms.push_back(t);
            end
            if (it.vm[2]) begin
               t.col = it.col[2];
               t.value = clamp64(dp[1]);
               terms.push_back(t);
            end
            rot_x_sum = accumulate(rot_x_sum, dp[1] * de[2] - dp[2] * de[1]);
         end
         if (cfg_en[KIND_RY]) begin
            t.row = cfg_rows[ROW_BITS*KIND_RY +: ROW_BITS];
            if (it.vm[0]) begin
               t.col = it.col[0];
               t.value = clamp64(dp[2]);
               terms.push_back(t);
            end
            if (it.vm[2]) begin
               t.col = it.col[2];
               t.value = clamp64(-dp[0]);
               terms.push_back(t);
            end
            rot_y_sum = accumulate(rot_y_sum, dp[2] * de[0] - dp[0] * de[2]);
         end
         if (cfg_en[KIND_RZ]) begin
            t.row = cfg_rows[ROW_BITS*KIND_RZ +: ROW_BITS];
            if (it.vm[0]) begin
               t.col = it.col[0];
               t.value = clamp64(-dp[1]);
               terms.push_back(t);
            end
            if (it.vm[1]) begin
               t.col = it.col[1];
               t.value = clamp64(dp[0]);
               terms.push_back(t);
            end
            rot_z_sum = accumulate(rot_z_sum, dp[0] * de[1] - dp[1] * de[0]);
         end
         if (cfg_en[KIND_SCALE]) begin
            t.row = cfg_rows[ROW_BITS*KIND_SCALE +: ROW_BITS];
            acc = '0;
            for (i = 0; i < 3; i++) begin
               if (it.vm[i]) begin
                  t.col = it.col[i];
                  t.value = clamp64(p[i]);
                  terms.push_back(t);
               end
               acc = acc + p[i] * e[i] + c[i] * c[i];
            end
            scale_sum = accumulate(scale_sum, acc);
         end
         if (point_count < MAX_POINTS) point_count = point_count + 1'b1;
      end
      for (i = 0; i < terms.size(); i++) begin
         t = terms[i];
         t.last = (i == terms.size() - 1);
         expected_terms.push_back(t);
      end
   endtask

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   always @(posedge clock) begin
      row_term_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_terms.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected transfer: row %0d col %0d value %0d",
                           rsp_row, rsp_col, $signed(rsp_value));
            end else begin
               want = expected_terms.pop_front();
               if (rsp_row !== want.row || rsp_col !== want.col
                   || rsp_value !== want.value
                   || rsp_is_misclosure !== want.is_misclosure
                   || rsp_last !== want.last) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: exp row %0d col %0d val %0d misc %b last %b,",
                               " got row %0d col %0d val %0d misc %b last %b"},
                              want.row, want.col, want.value, want.is_misclosure, want.last,
                              rsp_row, rsp_col, $signed(rsp_value), rsp_is_misclosure,
                              rsp_last);
               end
            end
         end
         if (req_valid && req_ready) begin
            build_expected_rows(drive_item);
            accept_count <= accept_count + 1;
         end
      end
   end

   always @(negedge clock) begin
      rsp_ready <= ready_pattern[ready_phase % 16];
      ready_phase <= ready_phase + 1;
      if (!reset && !(req_valid && accept_count == drive_taken)) begin
         if (req_valid) drive_taken++;
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_items.size() > 0) begin
            drive_item <= pending_items.pop_front();
            req_valid <= 1'b1;
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 10);
               gap_left = (sender_steady || $urandom_range(0, 3) == 0) ? 0
                        : $urandom_range(1, 15);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   function automatic logic [COORD_BITS-1:0] pick_coord();
      case ($urandom_range(0, 7))
         0: return COORD_MAX;
         1: return COORD_MIN;
         2, 3: return COORD_BITS'($signed($urandom) >>> 6);
         default: return COORD_BITS'({$urandom, $urandom});
      endcase
   endfunction

   function automatic point_item_type random_item(input int finish_odds);
      point_item_type it;
      int i;
      it.cmd = ($urandom_range(1, finish_odds) == 1) ? CMD_FINISH : CMD_POINT;
      for (i = 0; i < 3; i++) begin
         it.prov[i] = pick_coord();
         it.est[i] = ($urandom_range(0, 2) == 0) ? pick_coord()
                   : it.prov[i] + COORD_BITS'($signed($urandom) >>> 12);
         it.col[i] = COL_BITS'($urandom);
      end
      it.vm = 3'($urandom);
      return it;
   endfunction

   function automatic point_item_type fixed_point(input logic [COORD_BITS-1:0] pv,
                                                  input logic [COORD_BITS-1:0] ev,
                                                  input logic [2:0] vm,
                                                  input logic [COL_BITS-1:0] cv);
      point_item_type it;
      it.cmd = CMD_POINT;
      it.prov = {3{pv}};
      it.est = {3{ev}};
      it.vm = vm;
      it.col = {cv, ~cv, cv ^ 16'h5A5A};
      return it;
   endfunction

   task automatic configure(input logic [COORD_BITS-1:0] est_c[3],
                            input logic [COORD_BITS-1:0] ref_c[3],
                            input logic [NUM_KINDS-1:0] en,
                            input logic [CSR_DATA_BITS-1:0] rows);
      csr_index_type idx;
      int i;
      for (i = 0; i < 3; i++) begin
         cfg_est[i] = est_c[i];
         cfg_ref[i] = ref_c[i];
      end
      cfg_en = en;
      cfg_rows = rows;
      for (i = 0; i < 8; i++) begin
         idx = csr_index_type'(i);
         @(negedge clock);
         csr_wr_en <= 1'b1;
         csr_index <= idx;
         case (idx)
            CSR_EST_X, CSR_EST_Y, CSR_EST_Z: csr_wdata <= CSR_DATA_BITS'(est_c[i]);
            CSR_REF_X, CSR_REF_Y, CSR_REF_Z: csr_wdata <= CSR_DATA_BITS'(ref_c[i - 3]);
            CSR_ENABLE: csr_wdata <= CSR_DATA_BITS'(en);
            default: csr_wdata <= rows;
         endcase
      end
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic settle();
      while (pending_items.size() > 0 || req_valid || expected_terms.size() > 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   initial begin
      logic [COORD_BITS-1:0] ec[3], rc[3];
      point_item_type it;
      int ph, k, i;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      ec = '{'0, '0, '0};
      rc = '{'0, '0, '0};
      configure(ec, rc, ALL_KINDS, CSR_DATA_BITS'({$urandom, $urandom}));
      it = '0;
      it.cmd = CMD_FINISH;
      pending_items.push_back(it);
      for (k = 0; k < 8; k++)
         pending_items.push_back(fixed_point(k[0] ? COORD_MAX : COORD_MIN,
                                             k[0] ? COORD_MIN : COORD_MAX,
                                             3'(k), k[1] ? '1 : '0));
      pending_items.push_back(it);
      settle();

      ec = '{COORD_MAX, COORD_MAX, COORD_MAX};
      rc = '{COORD_MIN, COORD_MIN, COORD_MIN};
      configure(ec, rc, ALL_KINDS, '1);
      pending_items.push_back(fixed_point(COORD_MIN, COORD_MIN, 3'b111, COL_BITS'($urandom)));
      pending_items.push_back(fixed_point(COORD_MAX, COORD_MIN, 3'b111, COL_BITS'($urandom)));
      pending_items.push_back(it);
      pending_items.push_back(fixed_point(COORD_MIN, COORD_MAX, 3'b101, COL_BITS'($urandom)));
      pending_items.push_back(it);
      settle();

      ec = '{'0, '0, '0};
      configure(ec, ec, '0, '0);
      pending_items.push_back(fixed_point(COORD_MAX, COORD_MAX, 3'b111, COL_BITS'($urandom)));
      pending_items.push_back(it);
      settle();

      // drive the scale sum into positive saturation
      ec = '{COORD_MAX, COORD_MIN, COORD_MAX};
      rc = '{pick_coord(), pick_coord(), pick_coord()};
      configure(ec, rc, NUM_KINDS'((1 << KIND_SCALE) | (1 << KIND_RX) | (1 << KIND_DX)),
                CSR_DATA_BITS'({$urandom, $urandom}));
      for (k = 0; k < 90; k++)
         pending_items.push_back(fixed_point(COORD_MAX, COORD_MAX, 3'($urandom),
                                             COL_BITS'($urandom)));
      pending_items.push_back(it);
      settle();

      for (ph = 0; ph < 5; ph++) begin
         for (i = 0; i < 3; i++) begin
            ec[i] = pick_coord();
            rc[i] = pick_coord();
         end
         sender_steady = (ph == 2);
         ready_pattern = (ph == 2) ? '1 : 16'($urandom) | 16'h0001;
         configure(ec, rc, ($urandom_range(0, 2) == 0) ? ALL_KINDS : NUM_KINDS'($urandom),
                   CSR_DATA_BITS'({$urandom, $urandom}));
         for (k = 0; k < 15; k++) pending_items.push_back(random_item(6));
         settle();
      end

      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
